[src/panel_encoder_and_ladder_keys_defines.svh]
// ----------------------------------------------------------------------------
// Panel encoder and ladder keys: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PANEL_ENCODER_AND_LADDER_KEYS_DEFINES_SVH
`define PANEL_ENCODER_AND_LADDER_KEYS_DEFINES_SVH

// same-cycle implication
`define PEK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PEK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/pek_pkg.sv]
// ----------------------------------------------------------------------------
// pek_pkg
// Types, register map and constants for the panel encoder and ladder keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pek_pkg;

  localparam int ENC_SAMPLES_DEF = 4;
  localparam int KEY_SAMPLES_DEF = 8;
  localparam int NUM_KEYS        = 5;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LADDER_TOP   = 3'd0;
  localparam logic [2:0] REG_LADDER_K1_K2 = 3'd1;
  localparam logic [2:0] REG_LADDER_K2_K3 = 3'd2;
  localparam logic [2:0] REG_LADDER_K3_K4 = 3'd3;
  localparam logic [2:0] REG_LADDER_K4_K5 = 3'd4;

  localparam logic [7:0] LADDER_TOP_RST   = 8'd212;
  localparam logic [7:0] LADDER_K1_K2_RST = 8'd149;
  localparam logic [7:0] LADDER_K2_K3_RST = 8'd106;
  localparam logic [7:0] LADDER_K3_K4_RST = 8'd63;
  localparam logic [7:0] LADDER_K4_K5_RST = 8'd21;

  // encoder level/pending bits
  localparam int LVL_A  = 0;
  localparam int LVL_B  = 1;
  localparam int PEND_A = 2;
  localparam int PEND_B = 3;

  typedef struct packed {
    logic       enc_a;
    logic       enc_b;
    logic       adc_valid;
    logic [7:0] adc_sample;
    logic       collect;
  } in_item_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] key_states;
    logic signed [7:0]   position_delta;
    logic                changed;
  } out_item_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] k1_k2;
    logic [7:0] k2_k3;
    logic [7:0] k3_k4;
    logic [7:0] k4_k5;
  } ladder_cfg_t;

  typedef struct packed {
    logic [7:0] position;
    logic       stepped;
  } enc_status_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0] states;
    logic                changed;
  } key_status_t;

endpackage

`default_nettype wire

[src/pek_encoder.sv]
// ----------------------------------------------------------------------------
// pek_encoder
// Quadrature pin filtering, pending marks and the wrapping position count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "panel_encoder_and_ladder_keys_defines.svh"

module pek_encoder
  import pek_pkg::*;
#(
  parameter int ENC_SAMPLES = ENC_SAMPLES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step_en,
  input  wire logic  enc_a,
  input  wire logic  enc_b,
  input  wire logic  collect,
  output enc_status_t sts
);

  logic [ENC_SAMPLES-1:0] hist_a_r, hist_b_r;
  logic [ENC_SAMPLES-1:0] hist_a_nxt, hist_b_nxt;
  logic [3:0]             lp_r, lp_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic                   stepped;

  // A is handled before B; an A step consumes B's pending mark first
  always_comb begin
    hist_a_nxt = {hist_a_r[ENC_SAMPLES-2:0], enc_a};
    hist_b_nxt = {hist_b_r[ENC_SAMPLES-2:0], enc_b};
    lp_nxt     = lp_r;
    pos_nxt    = pos_r;
    stepped    = 1'b0;

    if (&hist_a_nxt) begin
      if (!lp_nxt[LVL_A]) begin
        if (lp_nxt[PEND_B]) begin
          pos_nxt        = pos_nxt - 8'd1;
          stepped        = 1'b1;
          lp_nxt[PEND_B] = 1'b0;
        end else begin
          lp_nxt[PEND_A] = 1'b1;
        end
      end
      lp_nxt[LVL_A] = 1'b1;
    end else if (hist_a_nxt == '0) begin
      lp_nxt[LVL_A]  = 1'b0;
      lp_nxt[PEND_A] = 1'b0;
    end

    if (&hist_b_nxt) begin
      if (!lp_nxt[LVL_B]) begin
        if (lp_nxt[PEND_A]) begin
          pos_nxt        = pos_nxt + 8'd1;
          stepped        = 1'b1;
          lp_nxt[PEND_A] = 1'b0;
        end else begin
          lp_nxt[PEND_B] = 1'b1;
        end
      end
      lp_nxt[LVL_B] = 1'b1;
    end else if (hist_b_nxt == '0) begin
      lp_nxt[LVL_B]  = 1'b0;
      lp_nxt[PEND_B] = 1'b0;
    end
  end

  assign sts.position = pos_nxt;
  assign sts.stepped  = stepped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_a_r <= '0;
      hist_b_r <= '0;
      lp_r     <= '0;
      pos_r    <= '0;
    end else if (step_en) begin
      hist_a_r <= hist_a_nxt;
      hist_b_r <= hist_b_nxt;
      lp_r     <= lp_nxt;
      pos_r    <= collect ? 8'd0 : pos_nxt;
    end
  end

  `PEK_ASSERT_NXT(a_enc_hold, !step_en, $stable(pos_r) && $stable(lp_r), "encoder state moved while idle")

endmodule

`default_nettype wire

[src/pek_keys.sv]
// ----------------------------------------------------------------------------
// pek_keys
// Ladder band classification and per-key debounce histories.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "panel_encoder_and_ladder_keys_defines.svh"

module pek_keys
  import pek_pkg::*;
#(
  parameter int KEY_SAMPLES = KEY_SAMPLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic        adc_valid,
  input  wire logic [7:0]  adc_sample,
  input  wire ladder_cfg_t cfg,
  output key_status_t      sts
);

  logic [KEY_SAMPLES-1:0] hist_r   [NUM_KEYS];
  logic [KEY_SAMPLES-1:0] hist_nxt [NUM_KEYS];
  logic [NUM_KEYS-1:0]    status_r, status_nxt;
  logic [NUM_KEYS-1:0]    hit;
  logic                   chg;

  // first matching band wins; band edges and high samples hit nothing
  always_comb begin
    hit = '0;
    if (adc_sample < cfg.top && adc_sample > cfg.k1_k2) begin
      hit[0] = 1'b1;
    end else if (adc_sample < cfg.k1_k2 && adc_sample > cfg.k2_k3) begin
      hit[1] = 1'b1;
    end else if (adc_sample < cfg.k2_k3 && adc_sample > cfg.k3_k4) begin
      hit[2] = 1'b1;
    end else if (adc_sample < cfg.k3_k4 && adc_sample > cfg.k4_k5) begin
      hit[3] = 1'b1;
    end else if (adc_sample < cfg.k4_k5) begin
      hit[4] = 1'b1;
    end
  end

  always_comb begin
    status_nxt = status_r;
    chg        = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hist_nxt[k] = {hist_r[k][KEY_SAMPLES-2:0], hit[k]};
      if (adc_valid) begin
        if ((&hist_nxt[k]) && !status_r[k]) begin
          status_nxt[k] = 1'b1;
          chg           = 1'b1;
        end else if (hist_nxt[k] == '0 && status_r[k]) begin
          status_nxt[k] = 1'b0;
          chg           = 1'b1;
        end
      end
    end
  end

  assign sts.states  = status_nxt;
  assign sts.changed = chg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hist_r[k] <= '0;
      end
      status_r <= '0;
    end else if (step_en && adc_valid) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
      status_r <= status_nxt;
    end
  end

  `PEK_ASSERT_NXT(a_keys_hold, !(step_en && adc_valid), $stable(status_r), "key state moved without a sample")
  `PEK_ASSERT_IMP(a_keys_onehot, 1'b1, $onehot0(hit), "more than one key band hit")

endmodule

`default_nettype wire

[src/panel_encoder_and_ladder_keys.sv]
// ----------------------------------------------------------------------------
// panel_encoder_and_ladder_keys
// Front panel quadrature encoder and resistor-ladder keypad debounce.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one tick item: both
//   encoder pin levels, an optional ladder sample and a collect request.
//   Result channel (out_valid/out_ready/out_data) returns one report per
//   item: debounced keys, position since the last collect, change flag.
//   APB-style port sets the five ladder thresholds at byte addresses 0..16.
// Timing:
//   An item is registered on acceptance in the input register and processed
//   from there; its report is loaded into the output register, raising
//   out_valid, once that register is empty or being drained. One item per
//   cycle sustained while out_ready holds; the state update is combinational
//   logic between the input register and the report register.
// Reset:
//   Synchronous, active low. Clears all filter, key and position state and
//   loads the default thresholds.
// Backpressure:
//   A stalled report holds in the output register; the input register
//   still accepts one more item, then in_ready drops until out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "panel_encoder_and_ladder_keys_defines.svh"

module panel_encoder_and_ladder_keys
  import pek_pkg::*;
#(
  parameter int ENC_SAMPLES = ENC_SAMPLES_DEF,
  parameter int KEY_SAMPLES = KEY_SAMPLES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  ladder_cfg_t cfg_r;
  logic        stg_valid_r;
  in_item_t    stg_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r, out_nxt;
  logic        change_flag_r, change_nxt;
  logic        advance;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  enc_status_t enc_sts;
  key_status_t key_sts;

  // ---------------- configuration ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.top   <= LADDER_TOP_RST;
      cfg_r.k1_k2 <= LADDER_K1_K2_RST;
      cfg_r.k2_k3 <= LADDER_K2_K3_RST;
      cfg_r.k3_k4 <= LADDER_K3_K4_RST;
      cfg_r.k4_k5 <= LADDER_K4_K5_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LADDER_TOP:   cfg_r.top   <= pwdata[7:0];
        REG_LADDER_K1_K2: cfg_r.k1_k2 <= pwdata[7:0];
        REG_LADDER_K2_K3: cfg_r.k2_k3 <= pwdata[7:0];
        REG_LADDER_K3_K4: cfg_r.k3_k4 <= pwdata[7:0];
        REG_LADDER_K4_K5: cfg_r.k4_k5 <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LADDER_TOP:   prdata = {{(DATA_W-8){1'b0}}, cfg_r.top};
      REG_LADDER_K1_K2: prdata = {{(DATA_W-8){1'b0}}, cfg_r.k1_k2};
      REG_LADDER_K2_K3: prdata = {{(DATA_W-8){1'b0}}, cfg_r.k2_k3};
      REG_LADDER_K3_K4: prdata = {{(DATA_W-8){1'b0}}, cfg_r.k3_k4};
      REG_LADDER_K4_K5: prdata = {{(DATA_W-8){1'b0}}, cfg_r.k4_k5};
      default:          prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  assign advance  = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        stg_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_nxt;
    end
  end

  // ---------------- processing ----------------
  pek_encoder #(
    .ENC_SAMPLES (ENC_SAMPLES)
  ) u_encoder (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .enc_a   (stg_data_r.enc_a),
    .enc_b   (stg_data_r.enc_b),
    .collect (stg_data_r.collect),
    .sts     (enc_sts)
  );

  pek_keys #(
    .KEY_SAMPLES (KEY_SAMPLES)
  ) u_keys (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .adc_valid  (stg_data_r.adc_valid),
    .adc_sample (stg_data_r.adc_sample),
    .cfg        (cfg_r),
    .sts        (key_sts)
  );

  assign change_nxt = change_flag_r || enc_sts.stepped || key_sts.changed;

  always_comb begin
    out_nxt.key_states     = key_sts.states;
    out_nxt.position_delta = enc_sts.position;
    out_nxt.changed        = change_nxt;
  end

  // report is formed first, collect clears afterwards
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_flag_r <= 1'b0;
    end else if (advance) begin
      change_flag_r <= stg_data_r.collect ? 1'b0 : change_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PEK_ASSERT_NXT(a_accept_stage, in_valid && in_ready, stg_valid_r, "accepted item not staged")
  `PEK_ASSERT_NXT(a_advance_out, advance, out_valid_r, "processed item lost its report")
  `PEK_ASSERT_NXT(a_collect_clr, advance && stg_data_r.collect, !change_flag_r, "collect left change flag set")

endmodule

`default_nettype wire

[test/panel_encoder_and_ladder_keys_tb.sv]
// ----------------------------------------------------------------------------
// panel_encoder_and_ladder_keys_tb
// Drives tick items (encoder pin levels, ladder samples, collect requests)
// into the block and checks every report against a cycle-free predictor of
// the encoder filter, the key band debounce and the collect behavior. The
// ladder thresholds are reprogrammed between phases, including extreme and
// disordered settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module panel_encoder_and_ladder_keys_tb;
  import pek_pkg::*;

  localparam int NO_KEY      = -1;
  localparam int MAX_SHOWN   = 10;
  localparam int DRAIN_SLACK = 8;
  localparam int PHASE_TICKS = 110;
  // addresses past the last threshold: writes there must not land anywhere
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  // Predicts the report for each accepted tick and checks reports in order.
  class panel_report_tracker;
    ladder_cfg_t                th;
    logic [ENC_SAMPLES_DEF-1:0] a_hist, b_hist;
    logic [3:0]                 enc_flags;
    logic [7:0]                 position;
    logic [KEY_SAMPLES_DEF-1:0] key_hist [NUM_KEYS];
    logic [NUM_KEYS-1:0]        keys_on;
    logic                       changed;
    out_item_t                  reports_due [$];
    int                         fail_count;
    int                         checked;

    function new();
      th.top   = LADDER_TOP_RST;
      th.k1_k2 = LADDER_K1_K2_RST;
      th.k2_k3 = LADDER_K2_K3_RST;
      th.k3_k4 = LADDER_K3_K4_RST;
      th.k4_k5 = LADDER_K4_K5_RST;
      a_hist = '0;
      b_hist = '0;
      enc_flags = '0;
      position = '0;
      foreach (key_hist[k]) key_hist[k] = '0;
      keys_on = '0;
      changed = 1'b0;
      fail_count = 0;
      checked = 0;
    endfunction

    function void set_threshold(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_LADDER_TOP:   th.top = val;
        REG_LADDER_K1_K2: th.k1_k2 = val;
        REG_LADDER_K2_K3: th.k2_k3 = val;
        REG_LADDER_K3_K4: th.k3_k4 = val;
        REG_LADDER_K4_K5: th.k4_k5 = val;
        default: ;
      endcase
    endfunction

    function void pin_update(logic [ENC_SAMPLES_DEF-1:0] hist, int lvl, int own,
                             int other, logic [7:0] step);
      if (hist == '1) begin
        if (!enc_flags[lvl]) begin
          if (enc_flags[other]) begin
            position = position + step;
            changed = 1'b1;
            enc_flags[other] = 1'b0;
          end else begin
            enc_flags[own] = 1'b1;
          end
        end
        enc_flags[lvl] = 1'b1;
      end else if (hist == '0) begin
        enc_flags[lvl] = 1'b0;
        enc_flags[own] = 1'b0;
      end
    endfunction

    // first matching band wins, so disordered thresholds still give one key
    function int band_of(logic [7:0] s);
      if (s < th.top && s > th.k1_k2) return 0;
      if (s < th.k1_k2 && s > th.k2_k3) return 1;
      if (s < th.k2_k3 && s > th.k3_k4) return 2;
      if (s < th.k3_k4 && s > th.k4_k5) return 3;
      if (s < th.k4_k5) return 4;
      return NO_KEY;
    endfunction

    function void note_tick(in_item_t t);
      out_item_t r;
      int        hit;
      a_hist = {a_hist[ENC_SAMPLES_DEF-2:0], t.enc_a};
      b_hist = {b_hist[ENC_SAMPLES_DEF-2:0], t.enc_b};
      // A before B: an A step clears B's pending mark first
      pin_update(a_hist, LVL_A, PEND_A, PEND_B, 8'hff);
      pin_update(b_hist, LVL_B, PEND_B, PEND_A, 8'h01);
      if (t.adc_valid) begin
        hit = band_of(t.adc_sample);
        for (int k = 0; k < NUM_KEYS; k++) begin
          key_hist[k] = {key_hist[k][KEY_SAMPLES_DEF-2:0], (k == hit) ? 1'b1 : 1'b0};
          if (key_hist[k] == '1 && !keys_on[k]) begin
            keys_on[k] = 1'b1;
            changed = 1'b1;
          end else if (key_hist[k] == '0 && keys_on[k]) begin
            keys_on[k] = 1'b0;
            changed = 1'b1;
          end
        end
      end
      r.key_states = keys_on;
      r.position_delta = position;
      r.changed = changed;
      reports_due.push_back(r);
      // report is formed before the collect clears
      if (t.collect) begin
        position = '0;
        changed = 1'b0;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      checked++;
      if (reports_due.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("report %0d arrived with nothing outstanding: keys %b pos %0d chg %b",
                   checked, got.key_states, got.position_delta, got.changed);
        return;
      end
      want = reports_due.pop_front();
      if (got.key_states !== want.key_states || got.position_delta !== want.position_delta ||
          got.changed !== want.changed) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("report %0d: keys exp %b got %b, pos exp %0d got %0d, chg exp %b got %b",
                   checked, want.key_states, got.key_states, want.position_delta,
                   got.position_delta, want.changed, got.changed);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  panel_report_tracker tracker;
  int                  idle_rate;

  // random tick generator state
  int                  enc_phase;
  int                  enc_dir;
  int                  enc_dwell;
  logic [7:0]          press_sample;
  int                  press_left;

  logic [7:0] probe_samples [18] = '{8'd0, 8'd20, 8'd21, 8'd22, 8'd62, 8'd63, 8'd64,
                                     8'd105, 8'd106, 8'd107, 8'd148, 8'd149, 8'd150,
                                     8'd211, 8'd212, 8'd213, 8'd255, 8'd128};

  panel_encoder_and_ladder_keys DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_tick(in_data);
      if (out_valid && out_ready) tracker.check_report(out_data);
    end
  end

  // result side stalls
  initial begin : ready_driver
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
        n = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Quadrature walk with random dwell (short dwells get filtered out), key
  // presses held for a run of samples, plus pin and ladder glitches.
  function automatic in_item_t next_panel_tick();
    in_item_t t;
    if (enc_dwell == 0) begin
      if ($urandom_range(0, 7) == 0) enc_dir = -enc_dir;
      enc_phase = (enc_phase + enc_dir) & 3;
      enc_dwell = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
    end
    enc_dwell--;
    t.enc_a = (enc_phase == 1 || enc_phase == 2);
    t.enc_b = (enc_phase >= 2);
    if ($urandom_range(0, 19) == 0) t.enc_a = ~t.enc_a;
    if ($urandom_range(0, 19) == 0) t.enc_b = ~t.enc_b;
    if (press_left == 0) begin
      press_left = $urandom_range(1, 20);
      if ($urandom_range(0, 7) == 0)
        press_sample = tracker.th[8*$urandom_range(0, 4) +: 8];
      else
        press_sample = 8'($urandom_range(0, 255));
    end
    press_left--;
    t.adc_valid = ($urandom_range(0, 6) != 0);
    t.adc_sample = press_sample;
    if (!t.adc_valid || $urandom_range(0, 24) == 0) t.adc_sample = 8'($urandom_range(0, 255));
    t.collect = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    if (idle_rate != 0 && $urandom_range(0, 99) < idle_rate) begin
      in_valid <= 1'b0;
      in_data <= in_item_t'($urandom_range(0, 2**$bits(in_item_t) - 1));
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic run_ticks(input int count);
    repeat (count) send_tick(next_panel_tick());
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (tracker.reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // setup phase, access phase, then psel is dropped before the next transfer
  task automatic write_threshold(input logic [2:0] idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom & 32'hffff_ff00) | val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_threshold(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_ladder(input logic [7:0] top, input logic [7:0] k1,
                              input logic [7:0] k2, input logic [7:0] k3,
                              input logic [7:0] k4);
    write_threshold(REG_LADDER_TOP, top);
    write_threshold(REG_LADDER_K1_K2, k1);
    write_threshold(REG_LADDER_K2_K3, k2);
    write_threshold(REG_LADDER_K3_K4, k3);
    write_threshold(REG_LADDER_K4_K5, k4);
  endtask

  initial begin
    in_item_t t;
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_rate = 0;
    enc_phase = 0;
    enc_dir = 1;
    enc_dwell = 0;
    press_sample = '0;
    press_left = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: band edges at the reset thresholds, sample-free ticks, an
    // up step (A then B), a down step (B then A) and two collects
    for (int i = 0; i < 24; i++) begin
      t.enc_a = (i >= 2 && i < 10) || (i >= 20);
      t.enc_b = (i >= 5 && i < 12) || (i >= 16);
      t.adc_valid = (i != 7) && (i < 18 || i == 22);
      t.adc_sample = (i < 18) ? probe_samples[i] : 8'ha5;
      t.collect = (i == 12 || i == 20);
      send_tick(t);
    end
    drain_reports();

    idle_rate = 30;
    run_ticks(PHASE_TICKS);
    drain_reports();

    // widest spread: top at max, lowest boundary at zero (fifth key unreachable)
    write_ladder(8'd255, 8'd192, 8'd128, 8'd64, 8'd0);
    idle_rate = 15;
    run_ticks(PHASE_TICKS);
    drain_reports();

    // collapsed bands: only the fifth key can hit; spare addresses ignored
    write_ladder(8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    for (int r = REG_SPARE_FIRST; r <= REG_SPARE_LAST; r++)
      write_threshold(3'(r), 8'($urandom_range(0, 255)));
    idle_rate = 40;
    run_ticks(PHASE_TICKS);
    drain_reports();

    // disordered thresholds
    write_ladder(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    idle_rate = 20;
    run_ticks(PHASE_TICKS);
    drain_reports();

    write_ladder(LADDER_TOP_RST, LADDER_K1_K2_RST, LADDER_K2_K3_RST, LADDER_K3_K4_RST,
                 LADDER_K4_K5_RST);
    idle_rate = 0;
    run_ticks(PHASE_TICKS);
    drain_reports();

    if (tracker.fail_count == 0 && tracker.reports_due.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
